>>> hdl/wps_pkg.sv
// Shared constants, command/status structs and the checksum helper for the
// windowed packetizer. Depends on nothing; every file but wps_ram uses it.
package wps_pkg;

  localparam int PACKET_BYTES = 128;
  localparam int WINDOW_MAX   = 10;
  localparam int QUEUE_DEPTH  = 4096;

  localparam int HEADER_LEN   = 7;
  localparam int PAYLOAD_MAX  = PACKET_BYTES - HEADER_LEN;
  localparam int PACKET_WORDS = (PACKET_BYTES + 1) / 2;

  localparam int QW  = $clog2(QUEUE_DEPTH);       // queue index
  localparam int FW  = QW + 1;                    // queue fill count
  localparam int NW  = $clog2(PAYLOAD_MAX + 1);   // payload count
  localparam int KW  = $clog2(PACKET_WORDS);      // packet word index
  localparam int BW  = KW + 1;                    // packet byte index
  localparam int IW  = $clog2(WINDOW_MAX + 1);    // packets in flight
  localparam int WLW = 4;                         // window limit register

  localparam logic [WLW-1:0] WINDOW_RESET = WLW'(10);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;

  typedef struct packed {
    logic take;        // input transfer this cycle
    logic pfx;         // write one length-prefix entry
    logic scan_start;  // clear scan counters and checksum
    logic scan_run;    // walk the queue into the packet buffer
    logic sum_seq_lo;
    logic sum_seq_hi;
    logic sum_len;
    logic commit;      // retire scanned entries, prime buffer read
    logic send;        // words are being offered
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic pfx_last;
    logic can_form;
    logic scan_done;
    logic word_last;
  } status_t;

  // Ones'-complement add with end-around carry.
  function automatic logic [16:0] ones_add(logic [16:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = acc + {1'b0, w};
    if (s[16]) begin
      s = {1'b0, s[15:0]} + 17'd1;
    end
    return s;
  endfunction

endpackage

>>> hdl/wps_if.sv
// Valid/ready channel interfaces for the packetizer: input items, packet
// words and the window limit write. Depends on wps_pkg.
interface wps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] msg_length;
  logic [7:0]  data_byte;
  modport source (output valid, op, msg_length, data_byte, input ready);
  modport sink   (input valid, op, msg_length, data_byte, output ready);
endinterface

interface wps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_word;
  logic        last_word;
  modport source (output valid, packet_word, last_word, input ready);
  modport sink   (input valid, packet_word, last_word, output ready);
endinterface

interface wps_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wps_pkg::WLW-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/windowed_packetizer_with_checksum.sv
// Top level of the windowed packetizer: joins the sequencer and datapath to
// the channel interfaces. Depends on wps_pkg, wps_if, wps_ctrl and wps_dp.
//
// Use: in_i takes one item per transfer (op 0 opens a message of msg_length
// bytes, op 1 carries one data byte, op 2 acknowledges one packet). cfg_i
// writes the window limit and is always ready; write it only while idle.
// Every item is handled by itself: in_i is ready only while the sequencer
// is idle. An accepted message start also makes four length-prefix writes
// into the queue RAM. When a packet can be formed, the item is followed by a
// queue walk over its n payload bytes (one queue RAM read per cycle), the
// checksum steps for the two sequence halves and the length, the step that
// primes the packet buffer, and then PACKET_WORDS words on out_o, one per
// cycle while out_o.ready is high; last_word marks the end.
// A stalled receiver holds the current word and no new item is taken until
// the whole packet has gone out. Reset empties the queue, clears sequence,
// in-flight count and open message, and sets the window limit to 10; the
// queue RAM needs no clearing pass.
module windowed_packetizer_with_checksum (
  input  logic      clk_i,
  input  logic      rst_ni,
  wps_in_if.sink    in_i,
  wps_out_if.source out_o,
  wps_cfg_if.sink   cfg_i
);
  import wps_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_i.ready = 1'b1;

  wps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  wps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .op_i          (in_i.op),
    .msg_length_i  (in_i.msg_length),
    .data_byte_i   (in_i.data_byte),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .packet_word_o (out_o.packet_word),
    .last_word_o   (out_o.last_word)
  );
endmodule

>>> hdl/wps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wps_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hdl/wps_ctrl.sv
// Sequencer for the packetizer: handles one item, then tries to form and
// send one packet. Depends on wps_pkg.
module wps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wps_pkg::status_t st_i,
  output wps_pkg::cmd_t    cmd_o
);
  import wps_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PREFIX = 9'b000000010,
    ST_CHECK  = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_SUMLO  = 9'b000010000,
    ST_SUMHI  = 9'b000100000,
    ST_SUMLEN = 9'b001000000,
    ST_PREP   = 9'b010000000,
    ST_SEND   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = st_i.start_ok ? ST_PREFIX : ST_CHECK;
        end
      end
      ST_PREFIX: begin
        cmd_o.pfx = 1'b1;
        if (st_i.pfx_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.scan_start = 1'b1;
        state_d = st_i.can_form ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) begin
          state_d = ST_SUMLO;
        end
      end
      ST_SUMLO: begin
        cmd_o.sum_seq_lo = 1'b1;
        state_d = ST_SUMHI;
      end
      ST_SUMHI: begin
        cmd_o.sum_seq_hi = 1'b1;
        state_d = ST_SUMLEN;
      end
      ST_SUMLEN: begin
        cmd_o.sum_len = 1'b1;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.commit = 1'b1;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        cmd_o.send = 1'b1;
        if (out_ready_i && st_i.word_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> hdl/wps_dp.sv
// Datapath of the packetizer: byte queue, window and sequence counters,
// packet buffer and checksum. Depends on wps_pkg and wps_ram.
module wps_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wps_pkg::cmd_t    cmd_i,
  output wps_pkg::status_t st_o,
  input  logic [1:0]       op_i,
  input  logic [15:0]      msg_length_i,
  input  logic [7:0]       data_byte_i,
  input  logic             cfg_we_i,
  input  logic [wps_pkg::WLW-1:0] cfg_data_i,
  input  logic             out_ready_i,
  output logic [15:0]      packet_word_o,
  output logic             last_word_o
);
  import wps_pkg::*;

  logic [QW-1:0]  head_q, head_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [FW-1:0]  marks_q, marks_d;
  logic [15:0]    expected_q, expected_d;
  logic [15:0]    len_q, len_d;
  logic [7:0]     last_byte_q, last_byte_d;
  logic [1:0]     pcnt_q, pcnt_d;
  logic [IW-1:0]  inflight_q, inflight_d;
  logic [31:0]    seq_q, seq_d;
  logic [WLW-1:0] win_q;
  logic [16:0]    acc_q, acc_d;
  logic [NW-1:0]  j_q, j_d;
  logic [NW-1:0]  n_q, n_d;
  logic           rvalid_q, rvalid_d;
  logic           marked_q, marked_d;
  logic [KW-1:0]  k_q, k_d;

  // Queue RAM ports.
  logic          q_we;
  logic [QW-1:0] q_waddr;
  logic [8:0]    q_wdata;
  logic [QW-1:0] q_raddr;
  logic [8:0]    q_rdata;

  // Packet buffer: even bytes in one RAM, odd bytes in the other.
  logic [BW-1:0] b_idx;
  logic          b_we;
  logic [KW-1:0] b_raddr;
  logic [7:0]    lo_rd, hi_rd;

  logic [QW-1:0]  tail;
  logic [WLW-1:0] eff_limit;
  logic           scan_take;
  logic           out_fire;

  assign tail      = head_q + fill_q[QW-1:0];
  assign q_raddr   = head_q + QW'(j_q);
  assign scan_take = cmd_i.scan_run && rvalid_q;
  assign b_idx     = BW'(n_q) + BW'(HEADER_LEN);
  assign b_we      = scan_take;
  assign out_fire  = cmd_i.send && out_ready_i;
  assign b_raddr   = k_q + KW'(out_fire);

  always_comb begin
    if (win_q > WLW'(WINDOW_MAX)) begin
      eff_limit = WLW'(WINDOW_MAX);
    end else if (win_q == '0) begin
      eff_limit = WLW'(1);
    end else begin
      eff_limit = win_q;
    end
  end

  always_comb begin
    st_o.start_ok  = (op_i == OP_START) && (expected_q == '0)
                  && (fill_q <= FW'(QUEUE_DEPTH - 4));
    st_o.pfx_last  = (pcnt_q == 2'd3);
    st_o.can_form  = (WLW'(inflight_q) < eff_limit)
                  && ((fill_q >= FW'(PAYLOAD_MAX)) || (marks_q != '0));
    st_o.scan_done = rvalid_q && (q_rdata[8] || (n_q == NW'(PAYLOAD_MAX - 1)));
    st_o.word_last = (k_q == KW'(PACKET_WORDS - 1));
  end

  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    marks_d     = marks_q;
    expected_d  = expected_q;
    len_d       = len_q;
    last_byte_d = last_byte_q;
    pcnt_d      = pcnt_q;
    inflight_d  = inflight_q;
    seq_d       = seq_q;
    acc_d       = acc_q;
    j_d         = j_q;
    n_d         = n_q;
    rvalid_d    = rvalid_q;
    marked_d    = marked_q;
    k_d         = k_q;
    q_we        = 1'b0;
    q_waddr     = tail;
    q_wdata     = '0;

    if (cmd_i.take) begin
      unique case (op_i)
        OP_START: begin
          if (st_o.start_ok) begin
            expected_d = msg_length_i;
            len_d      = msg_length_i;
            pcnt_d     = '0;
          end
        end
        OP_DATA: begin
          if (expected_q != '0) begin
            expected_d = expected_q - 16'd1;
            if (fill_q != FW'(QUEUE_DEPTH)) begin
              q_we        = 1'b1;
              q_wdata     = {(expected_q == 16'd1), data_byte_i};
              fill_d      = fill_q + FW'(1);
              last_byte_d = data_byte_i;
              marks_d     = marks_q + FW'(expected_q == 16'd1);
            end else if (expected_q == 16'd1) begin
              // The queue is full: the end mark moves onto the newest entry.
              q_we    = 1'b1;
              q_waddr = tail - QW'(1);
              q_wdata = {1'b1, last_byte_q};
              marks_d = marks_q + FW'(1);
            end
          end
        end
        OP_ACK: begin
          if (inflight_q != '0) begin
            inflight_d = inflight_q - IW'(1);
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.pfx) begin
      q_we = 1'b1;
      unique case (pcnt_q)
        2'd0:    q_wdata = {1'b0, len_q[7:0]};
        2'd1:    q_wdata = {1'b0, len_q[15:8]};
        2'd2:    q_wdata = '0;
        default: q_wdata = {(len_q == '0), 8'h00};
      endcase
      fill_d      = fill_q + FW'(1);
      pcnt_d      = pcnt_q + 2'd1;
      last_byte_d = q_wdata[7:0];
      marks_d     = marks_q + FW'(q_wdata[8]);
    end

    if (cmd_i.scan_start) begin
      j_d      = '0;
      n_d      = '0;
      acc_d    = '0;
      rvalid_d = 1'b0;
      marked_d = 1'b0;
    end

    if (cmd_i.scan_run) begin
      j_d      = j_q + NW'(1);
      rvalid_d = 1'b1;
      if (rvalid_q) begin
        n_d   = n_q + NW'(1);
        acc_d = ones_add(acc_q, b_idx[0] ? {q_rdata[7:0], 8'h00}
                                          : {8'h00, q_rdata[7:0]});
        if (q_rdata[8]) begin
          marked_d = 1'b1;
        end
      end
    end

    if (cmd_i.sum_seq_lo) acc_d = ones_add(acc_q, seq_q[15:0]);
    if (cmd_i.sum_seq_hi) acc_d = ones_add(acc_q, seq_q[31:16]);
    if (cmd_i.sum_len)    acc_d = ones_add(acc_q, 16'(n_q));

    if (cmd_i.commit) begin
      head_d  = head_q + QW'(n_q);
      fill_d  = fill_q - FW'(n_q);
      marks_d = marks_q - FW'(marked_q);
      k_d     = '0;
    end

    if (out_fire) begin
      k_d = k_q + KW'(1);
      if (st_o.word_last) begin
        seq_d      = seq_q + 32'd1;
        inflight_d = inflight_q + IW'(1);
      end
    end
  end

  // Word assembly; bytes past the payload read as zero.
  logic [BW:0] byte_lim;
  logic [7:0]  lo_m, hi_m;

  assign byte_lim = (BW + 1)'(n_q) + (BW + 1)'(HEADER_LEN);
  assign lo_m = ({1'b0, k_q, 1'b0} < byte_lim) ? lo_rd : 8'h00;
  assign hi_m = ({1'b0, k_q, 1'b1} < byte_lim) ? hi_rd : 8'h00;

  always_comb begin
    priority if (k_q == KW'(0)) begin
      packet_word_o = ~acc_q[15:0];
    end else if (k_q == KW'(1)) begin
      packet_word_o = seq_q[15:0];
    end else if (k_q == KW'(2)) begin
      packet_word_o = seq_q[31:16];
    end else if (k_q == KW'(3)) begin
      packet_word_o = {hi_m, 8'(n_q)};
    end else begin
      packet_word_o = {hi_m, lo_m};
    end
  end
  assign last_word_o = st_o.word_last;

  wps_ram #(.W(9), .D(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  wps_ram #(.W(8), .D(PACKET_WORDS)) u_buf_lo (
    .clk_i   (clk_i),
    .we_i    (b_we && !b_idx[0]),
    .waddr_i (b_idx[BW-1:1]),
    .wdata_i (q_rdata[7:0]),
    .raddr_i (b_raddr),
    .rdata_o (lo_rd)
  );

  wps_ram #(.W(8), .D(PACKET_WORDS)) u_buf_hi (
    .clk_i   (clk_i),
    .we_i    (b_we && b_idx[0]),
    .waddr_i (b_idx[BW-1:1]),
    .wdata_i (q_rdata[7:0]),
    .raddr_i (b_raddr),
    .rdata_o (hi_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      marks_q     <= '0;
      expected_q  <= '0;
      pcnt_q      <= '0;
      inflight_q  <= '0;
      seq_q       <= '0;
      win_q       <= WINDOW_RESET;
      rvalid_q    <= 1'b0;
      marked_q    <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      acc_q       <= '0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      marks_q     <= marks_d;
      expected_q  <= expected_d;
      pcnt_q      <= pcnt_d;
      inflight_q  <= inflight_d;
      seq_q       <= seq_d;
      rvalid_q    <= rvalid_d;
      marked_q    <= marked_d;
      k_q         <= k_d;
      j_q         <= j_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      if (cfg_we_i) begin
        win_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    last_byte_q <= last_byte_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  a_marks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marks_q <= fill_q)
    else $error("more end marks than queued entries");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= IW'(WINDOW_MAX))
    else $error("packets in flight exceed window maximum");

  a_ack_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && (op_i == OP_ACK) && (inflight_q != '0)
    |=> inflight_q == $past(inflight_q) - IW'(1))
    else $error("acknowledgement did not free a slot");
endmodule
